// File: src/inverse_cdf_table_interpolator_defines.svh
// Assertion macros for the table interpolator.
// Taken in by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef INVERSE_CDF_TABLE_INTERPOLATOR_DEFINES_SVH
`define INVERSE_CDF_TABLE_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTH
`define ICDF_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ICDF_ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ICDF_ASSERT_IMP(label, a, c)
`define ICDF_ASSERT_NXT(label, a, c)
`endif
`endif

// File: src/icdf_pkg.sv
// Shared codes and constants for the table interpolator.
// No dependencies.
package icdf_pkg;
    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_INV  = 2'd1;
    localparam logic [1:0] OP_FWD  = 2'd2;

    localparam logic [2:0] ST_LOADED = 3'd0;
    localparam logic [2:0] ST_INTERP = 3'd1;
    localparam logic [2:0] ST_LOW    = 3'd2;
    localparam logic [2:0] ST_HIGH   = 3'd3;
    localparam logic [2:0] ST_ZERO   = 3'd4;

    localparam logic CFG_ENTRIES = 1'b0;
    localparam logic CFG_SCALE   = 1'b1;

    localparam logic [8:0]  ENTRIES_RESET = 9'd2;
    localparam logic [30:0] SCALE_RESET   = 31'd65536;
endpackage

// File: src/icdf_mem.sv
// Key and value tables: one write port, one registered read port.
// Depends on nothing but its parameters.
module icdf_mem #(
    parameter int DEPTH = 256,
    parameter int IW    = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IW-1:0]        waddr,
    input  logic [30:0]          wkey,
    input  logic signed [31:0]   wval,
    input  logic [IW-1:0]        raddr,
    output logic [30:0]          rkey,
    output logic signed [31:0]   rval
);
    logic [30:0]        key_mem [DEPTH];
    logic signed [31:0] val_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            val_mem[waddr] <= wval;
        end
        rkey <= key_mem[raddr];
        rval <= val_mem[raddr];
    end
endmodule

// File: src/icdf_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// Depends on nothing but its parameter.
module icdf_div #(
    parameter int DVW = 56
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [31:0]    divisor,
    output logic           busy,
    output logic           done,
    output logic [DVW-1:0] quotient
);
    localparam int CW = $clog2(DVW + 1);

    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [31:0]    rem_reg;
    logic [DVW-1:0] dvd_reg;
    logic [DVW-1:0] quo_reg;
    logic [31:0]    div_reg;
    logic [32:0]    trial;
    logic [32:0]    diff;
    logic           ge;

    assign trial = {rem_reg, dvd_reg[DVW-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(DVW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            quo_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so 32 bits hold it
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            dvd_reg <= {dvd_reg[DVW-2:0], 1'b0};
            quo_reg <= {quo_reg[DVW-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// File: src/inverse_cdf_table_interpolator.sv
// Inverse/forward piecewise-linear table lookup, Q16.16, one item at a time.
// Inverse lookup time is set by the one-entry-per-cycle key scan and the bit-serial divider;
// forward lookups use the divider too. Clamped lookups and a zero span skip the divider.
// A new item is taken only after the previous one has passed S_OUT.
// Reset is asynchronous, active low; clears control and config, tables stay undefined.
`include "inverse_cdf_table_interpolator_defines.svh"
module inverse_cdf_table_interpolator #(
    parameter int TABLE_DEPTH = icdf_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [7:0]         entry_index,
    input  logic [30:0]        key_word,
    input  logic signed [31:0] value_word,
    input  logic [23:0]        uniform_sample,
    input  logic signed [31:0] position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    output logic [2:0]         status,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_data
);
    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int DVW = 48 + IW;
    localparam int MBW = (IW + 1 > 25) ? IW + 1 : 25;
    localparam int PW  = 34 + MBW;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_Q      = 5'd1;
    localparam logic [4:0] S_K0     = 5'd2;
    localparam logic [4:0] S_KN     = 5'd3;
    localparam logic [4:0] S_SCAN   = 5'd4;
    localparam logic [4:0] S_DIVI   = 5'd5;
    localparam logic [4:0] S_DWAIT  = 5'd6;
    localparam logic [4:0] S_VA     = 5'd7;
    localparam logic [4:0] S_VB     = 5'd8;
    localparam logic [4:0] S_VC     = 5'd9;
    localparam logic [4:0] S_MUL    = 5'd10;
    localparam logic [4:0] S_ADD    = 5'd11;
    localparam logic [4:0] S_VFETCH = 5'd12;
    localparam logic [4:0] S_F0     = 5'd13;
    localparam logic [4:0] S_F1     = 5'd14;
    localparam logic [4:0] S_F2     = 5'd15;
    localparam logic [4:0] S_FMUL   = 5'd16;
    localparam logic [4:0] S_FDIV   = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0]  state_reg, state_next;
    logic [8:0]  entries_reg;
    logic [30:0] scale_reg;

    logic [1:0]         op_reg;
    logic [23:0]        u_reg;
    logic signed [31:0] x_reg;
    logic [30:0]        q_reg, lo_reg, prev_reg, v1_reg, v2_reg;
    logic [IW-1:0]      cnt_reg, seg_reg;
    logic signed [32:0] ya_reg, yb_reg;
    logic [31:0]        a_reg, b_reg;
    logic [15:0]        frac_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [31:0] pend_res_reg, res_reg;
    logic [2:0]         pend_st_reg, st_reg;
    logic               out_valid_reg;

    logic [31:0]   n_wide;
    logic [IW-1:0] nm1;
    logic [IW-1:0] raddr;
    logic [30:0]   rkey;
    logic signed [31:0] rval;
    logic          mem_we;
    logic signed [33:0]    mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [32:0]    col;
    logic signed [32:0]    span, tdiff, blend_off;
    logic [32:0]           amag, bmag;
    logic                  div_start, div_busy, div_done;
    logic [DVW-1:0]        div_dvd, div_quo;
    logic [31:0]           div_dsr;
    logic [30:0]           cur_key;
    logic                  in_acc;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign mem_we   = in_acc && op == icdf_pkg::OP_LOAD
                      && 32'(entry_index) < 32'(TABLE_DEPTH);

    always_comb
    begin
        if (entries_reg < 9'd2)
            n_wide = 32'd2;
        else if (32'(entries_reg) > 32'(TABLE_DEPTH))
            n_wide = 32'(TABLE_DEPTH);
        else
            n_wide = 32'(entries_reg);
    end
    assign nm1 = IW'(n_wide - 32'd1);

    icdf_mem #(.DEPTH(TABLE_DEPTH), .IW(IW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (IW'(entry_index)),
        .wkey  (key_word),
        .wval  (value_word),
        .raddr (raddr),
        .rkey  (rkey),
        .rval  (rval)
    );

    icdf_div #(.DVW(DVW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // lookup column: values for inverse, keys for forward
    assign col = (op_reg == icdf_pkg::OP_INV) ? 33'(rval) : {2'b0, rkey};
    assign cur_key = rkey;
    assign span  = 33'(rval) - ya_reg;
    assign tdiff = 33'(x_reg) - ya_reg;
    assign amag  = tdiff[32] ? -tdiff : tdiff;
    assign bmag  = span[32] ? -span : span;
    assign blend_off = prod_reg[48:16];

    assign div_start = (state_reg == S_DIVI) || (state_reg == S_FDIV);
    assign div_dvd = (state_reg == S_FDIV)
                     ? {prod_reg[32+IW-1:0], 16'b0}
                     : DVW'({q_reg - v1_reg, 16'b0});
    assign div_dsr = (state_reg == S_FDIV) ? b_reg : {1'b0, v2_reg - v1_reg};

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_Q:
            begin
                mul_a = {3'b0, scale_reg};
                mul_b = MBW'(u_reg);
            end
            S_FMUL:
            begin
                mul_a = {2'b0, a_reg};
                mul_b = MBW'(nm1);
            end
            S_MUL:
            begin
                mul_a = 34'(yb_reg - ya_reg);
                mul_b = MBW'(frac_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        raddr = '0;
        case (state_reg)
            S_Q:    raddr = '0;
            S_K0:   raddr = nm1;
            // last entry only for a high or last-key result; the scan starts at entry 0
            S_KN:   raddr = (q_reg >= lo_reg && q_reg >= cur_key) ? nm1 : '0;
            S_SCAN: raddr = cnt_reg + 1'b1;
            S_VA:   raddr = seg_reg;
            S_VB:   raddr = seg_reg + 1'b1;
            S_F0:   raddr = '0;
            S_F1:   raddr = nm1;
            S_F2:   raddr = (tdiff[32] == span[32] && amag < bmag) ? '0 :
                            ((tdiff[32] != span[32] && tdiff != 0) ? '0 : nm1);
            default: raddr = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == icdf_pkg::OP_INV)
                        state_next = S_Q;
                    else if (op == icdf_pkg::OP_FWD)
                        state_next = S_F0;
                    else
                        state_next = S_OUT;
                end
            end
            S_Q:  state_next = S_K0;
            S_K0: state_next = S_KN;
            S_KN:
            begin
                if (q_reg < lo_reg || q_reg >= cur_key)
                    state_next = S_VFETCH;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:  state_next = (cnt_reg == nm1) ? S_DIVI : S_SCAN;
            S_DIVI:  state_next = S_DWAIT;
            S_FDIV:  state_next = S_DWAIT;
            S_DWAIT: state_next = div_done ? S_VA : S_DWAIT;
            S_VA:    state_next = S_VB;
            S_VB:    state_next = S_VC;
            S_VC:    state_next = S_MUL;
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = S_OUT;
            S_VFETCH: state_next = S_OUT;
            S_F0:    state_next = S_F1;
            S_F1:    state_next = S_F2;
            S_F2:
            begin
                if (span == 0)
                    state_next = S_OUT;
                else if (tdiff[32] != span[32] && tdiff != 0)
                    state_next = S_VFETCH;
                else if (amag >= bmag)
                    state_next = S_VFETCH;
                else
                    state_next = S_FMUL;
            end
            S_FMUL:  state_next = S_FDIV;
            S_OUT:   state_next = (out_valid_reg && out_stall) ? S_OUT : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entries_reg   <= icdf_pkg::ENTRIES_RESET;
            scale_reg     <= icdf_pkg::SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == icdf_pkg::CFG_ENTRIES)
                    entries_reg <= cfg_data[8:0];
                else
                    scale_reg <= cfg_data;
            end
            if (state_reg == S_OUT && !(out_valid_reg && out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
        case (state_reg)
            S_IDLE:
            begin
                op_reg       <= op;
                u_reg        <= uniform_sample;
                x_reg        <= position;
                pend_res_reg <= '0;
                pend_st_reg  <= icdf_pkg::ST_LOADED;
            end
            S_K0:
            begin
                q_reg  <= prod_reg[54:24];
                lo_reg <= cur_key;
            end
            S_KN:
            begin
                cnt_reg <= '0;
                if (q_reg < lo_reg)
                    pend_st_reg <= icdf_pkg::ST_LOW;
                else if (q_reg > cur_key)
                    pend_st_reg <= icdf_pkg::ST_HIGH;
                else
                    pend_st_reg <= icdf_pkg::ST_INTERP;
            end
            S_SCAN:
            begin
                // last matching segment wins
                if (cnt_reg != '0 && prev_reg <= q_reg && q_reg < cur_key)
                begin
                    seg_reg <= cnt_reg - 1'b1;
                    v1_reg  <= prev_reg;
                    v2_reg  <= cur_key;
                end
                prev_reg <= cur_key;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    frac_reg <= div_quo[15:0];
                    if (op_reg == icdf_pkg::OP_FWD)
                        seg_reg <= div_quo[16+IW-1:16];
                end
            end
            S_VB: ya_reg <= col;
            S_VC: yb_reg <= col;
            S_ADD:
            begin
                pend_res_reg <= 32'(ya_reg + blend_off);
                pend_st_reg  <= icdf_pkg::ST_INTERP;
            end
            S_VFETCH: pend_res_reg <= col[31:0];
            S_F1: ya_reg <= 33'(rval);
            S_F2:
            begin
                a_reg <= amag[31:0];
                b_reg <= bmag[31:0];
                if (span == 0)
                    pend_st_reg <= icdf_pkg::ST_ZERO;
                else if (tdiff[32] != span[32] && tdiff != 0)
                    pend_st_reg <= icdf_pkg::ST_LOW;
                else if (amag > bmag)
                    pend_st_reg <= icdf_pkg::ST_HIGH;
                else
                    pend_st_reg <= icdf_pkg::ST_INTERP;
            end
            S_OUT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    res_reg <= pend_res_reg;
                    st_reg  <= pend_st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign status       = st_reg;

    `ICDF_ASSERT_NXT(a_accept_busy, in_acc, state_reg != S_IDLE)
    `ICDF_ASSERT_IMP(a_div_start_free, div_start, !div_busy)
    `ICDF_ASSERT_IMP(a_idle_div_quiet, state_reg == S_IDLE, !div_busy)
    `ICDF_ASSERT_IMP(a_zero_span_value, out_valid && status == icdf_pkg::ST_ZERO,
                     result_value == 32'sd0)
endmodule
